@@ hw/rtl/calclk_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar clock package
// Shared widths, codes, reset values and digit helpers for the calendar clock.
// ----------------------------------------------------------------------------
package calclk_pkg;

    localparam int OP_W        = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int DWELL_W     = 8;
    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int SEC_W       = 6;
    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 14;
    localparam int PAIR_W      = 7;
    localparam int SEGS_W      = 64;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = HOUR_W + MIN_W + SEC_W + DAY_W + MONTH_W + YEAR_W + SEGS_W;

    // Item kinds
    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_BUMP_HOUR = 2'd1;
    localparam logic [OP_W-1:0] OP_BUMP_MIN  = 2'd2;
    localparam logic [OP_W-1:0] OP_BUMP_SEC  = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_DWELL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATE_DWELL = 1'b1;

    localparam logic [DWELL_W-1:0] TIME_DWELL_RST = 8'd8;
    localparam logic [DWELL_W-1:0] DATE_DWELL_RST = 8'd2;

    localparam logic [SEC_W-1:0]   SEC_RST     = 6'd30;
    localparam logic [MIN_W-1:0]   MIN_RST     = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_RST    = 5'd23;
    localparam logic [DAY_W-1:0]   DAY_RST     = 5'd31;
    localparam logic [MONTH_W-1:0] MONTH_RST   = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_RST    = 14'd2025;
    localparam logic [PAIR_W-1:0]  YEAR_HI_RST = 7'd20;
    localparam logic [PAIR_W-1:0]  YEAR_LO_RST = 7'd25;

    localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_LAST  = 14'd9999;
    localparam logic [PAIR_W-1:0]  PAIR_LAST  = 7'd99;

    typedef logic [7:0]  seg_byte_t;
    typedef logic [15:0] seg_pair_t;

    localparam seg_byte_t SEG_BLANK = 8'hFF;

    function automatic seg_byte_t seg_of(input logic [3:0] digit);
        seg_byte_t code;
        unique case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            default: code = 8'h90;
        endcase
        return code;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Two segment bytes for a value of 0..99; tens come from a multiply by
    // 205/2048, which is exact for every 7-bit input.
    function automatic seg_pair_t two_digits(input logic [PAIR_W-1:0] value);
        logic [14:0]       prod;
        logic [3:0]        tens;
        logic [PAIR_W-1:0] tens_x10;
        logic [PAIR_W-1:0] ones;
        prod     = 15'(value) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = PAIR_W'({tens, 3'b000}) + PAIR_W'({tens, 1'b0});
        ones     = value - tens_x10;
        return {seg_of(tens), seg_of(ones[3:0])};
    endfunction

endpackage

@@ hw/rtl/calendar_clock_with_segment_display_unit.sv @@
// ----------------------------------------------------------------------------
// Calendar clock with segment display
// Time-of-day and date counters with an alternating eight-digit display.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata[1:0] is the item kind (tick or bump of hour,
// minute or second), s_axis_tuser[0] is the edit hold flag. A tick beat gives
// one output beat with the date and time after the tick and eight active-low
// segment bytes; bump beats are applied only under edit hold and give none.
// Configuration writes (index 0 time dwell, index 1 date dwell) are taken in
// any cycle through cfg_valid/cfg_ready and should come while the block idles.
// A tick waits in the input register while the output beat is stalled.
// Throughput: one beat per cycle but for such waits; each item goes through
// an input register and a single update stage whose carry chain and digit
// split feed the output register directly.
// Stall: when the output beat is not taken, the input register still takes one
// more beat; bump beats keep flowing while a result waits.
// Reset: the clock reads 23:59:30 on 31-12-2025, time view, dwell count zero,
// dwell registers 8 and 2, both stream registers empty.
// ----------------------------------------------------------------------------
module calendar_clock_with_segment_display_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [calclk_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // op[1:0], zeros
    input  logic [0:0]                            s_axis_tuser,  // edit_hold
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // hour[4:0], minute[10:5], second[16:11], day[21:17], month[25:22],
    // year[39:26], segments[103:40]
    output logic [calclk_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [0:0]                            m_axis_tuser,  // showing_date
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [calclk_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [calclk_pkg::DWELL_W-1:0]        cfg_data
);

    logic                               in_valid_reg;
    logic [calclk_pkg::OP_W-1:0]        in_op_reg;
    logic                               in_hold_reg;

    logic [calclk_pkg::SEC_W-1:0]       sec_reg,     sec_next;
    logic [calclk_pkg::MIN_W-1:0]       min_reg,     min_next;
    logic [calclk_pkg::HOUR_W-1:0]      hour_reg,    hour_next;
    logic [calclk_pkg::DAY_W-1:0]       day_reg,     day_next;
    logic [calclk_pkg::MONTH_W-1:0]     month_reg,   month_next;
    logic [calclk_pkg::YEAR_W-1:0]      year_reg,    year_next;
    logic [calclk_pkg::PAIR_W-1:0]      year_hi_reg, year_hi_next;
    logic [calclk_pkg::PAIR_W-1:0]      year_lo_reg, year_lo_next;
    logic                               view_date_reg, view_date_next;
    logic [calclk_pkg::DWELL_W-1:0]     dwell_reg,   dwell_next;
    logic [calclk_pkg::DWELL_W-1:0]     time_dwell_reg;
    logic [calclk_pkg::DWELL_W-1:0]     date_dwell_reg;

    logic                               out_valid_reg, out_valid_next;
    logic [calclk_pkg::OUT_DATA_W-1:0]  out_data_reg,  out_data_next;
    logic                               out_date_reg;

    logic advance;
    logic is_tick;
    logic tick_en;
    logic bump_en;
    logic sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
    logic [calclk_pkg::DWELL_W-1:0]     dwell_inc;
    logic                               view_switch;
    logic [calclk_pkg::SEGS_W-1:0]      segs;

    // A bump never needs the output register, so it moves on even under a stall.
    assign is_tick       = (in_op_reg == calclk_pkg::OP_TICK);
    assign advance       = in_valid_reg && (!is_tick || !out_valid_reg || m_axis_tready);
    assign tick_en       = advance && is_tick;
    assign bump_en       = advance && !is_tick && in_hold_reg;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg   <= s_axis_tdata[calclk_pkg::OP_W-1:0];
            in_hold_reg <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_dwell_reg <= calclk_pkg::TIME_DWELL_RST;
            date_dwell_reg <= calclk_pkg::DATE_DWELL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                calclk_pkg::CFG_TIME_DWELL: time_dwell_reg <= cfg_data;
                calclk_pkg::CFG_DATE_DWELL: date_dwell_reg <= cfg_data;
            endcase
        end
    end

    // Carry chain of the one-second advance.
    assign sec_wrap   = (sec_reg >= calclk_pkg::SEC_LAST);
    assign min_wrap   = sec_wrap && (min_reg >= calclk_pkg::MIN_LAST);
    assign hour_wrap  = min_wrap && (hour_reg >= calclk_pkg::HOUR_LAST);
    assign day_wrap   = hour_wrap && (day_reg >= calclk_pkg::month_len(month_reg));
    assign month_wrap = day_wrap && (month_reg >= calclk_pkg::MONTH_LAST);

    always_comb
    begin
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        year_hi_next = year_hi_reg;
        year_lo_next = year_lo_reg;

        if (tick_en && !in_hold_reg)
        begin
            sec_next = sec_wrap ? '0 : sec_reg + 1'b1;
            if (sec_wrap)
            begin
                min_next = min_wrap ? '0 : min_reg + 1'b1;
            end
            if (min_wrap)
            begin
                hour_next = hour_wrap ? '0 : hour_reg + 1'b1;
            end
            if (hour_wrap)
            begin
                day_next = day_wrap ? calclk_pkg::DAY_W'(1) : day_reg + 1'b1;
            end
            if (day_wrap)
            begin
                month_next = month_wrap ? calclk_pkg::MONTH_W'(1) : month_reg + 1'b1;
            end
            if (month_wrap)
            begin
                if (year_reg >= calclk_pkg::YEAR_LAST)
                begin
                    year_next    = '0;
                    year_hi_next = '0;
                    year_lo_next = '0;
                end
                else
                begin
                    year_next = year_reg + 1'b1;
                    if (year_lo_reg >= calclk_pkg::PAIR_LAST)
                    begin
                        year_lo_next = '0;
                        year_hi_next = year_hi_reg + 1'b1;
                    end
                    else
                    begin
                        year_lo_next = year_lo_reg + 1'b1;
                    end
                end
            end
        end
        else if (bump_en)
        begin
            unique case (in_op_reg)
                calclk_pkg::OP_BUMP_HOUR:
                    hour_next = (hour_reg >= calclk_pkg::HOUR_LAST) ? '0 : hour_reg + 1'b1;
                calclk_pkg::OP_BUMP_MIN:
                    min_next = (min_reg >= calclk_pkg::MIN_LAST) ? '0 : min_reg + 1'b1;
                calclk_pkg::OP_BUMP_SEC:
                    sec_next = (sec_reg >= calclk_pkg::SEC_LAST) ? '0 : sec_reg + 1'b1;
                default:
                    sec_next = sec_reg;
            endcase
        end
    end

    // The view in force before this tick picks the digits; the dwell count
    // then decides the view for the next tick.
    assign dwell_inc   = dwell_reg + 1'b1;
    assign view_switch = view_date_reg ? (dwell_inc >= date_dwell_reg)
                                       : (dwell_inc >= time_dwell_reg);

    always_comb
    begin
        view_date_next = view_date_reg;
        dwell_next     = dwell_reg;
        if (tick_en)
        begin
            view_date_next = view_switch ? !view_date_reg : view_date_reg;
            dwell_next     = view_switch ? '0 : dwell_inc;
        end
    end

    always_comb
    begin
        if (view_date_reg)
        begin
            segs = {calclk_pkg::two_digits(calclk_pkg::PAIR_W'(day_next)),
                    calclk_pkg::two_digits(calclk_pkg::PAIR_W'(month_next)),
                    calclk_pkg::two_digits(year_hi_next),
                    calclk_pkg::two_digits(year_lo_next)};
        end
        else
        begin
            segs = {calclk_pkg::two_digits(calclk_pkg::PAIR_W'(hour_next)),
                    calclk_pkg::two_digits(calclk_pkg::PAIR_W'(min_next)),
                    calclk_pkg::two_digits(calclk_pkg::PAIR_W'(sec_next)),
                    calclk_pkg::SEG_BLANK, calclk_pkg::SEG_BLANK};
        end
    end

    assign out_data_next  = {segs, year_next, month_next, day_next,
                             sec_next, min_next, hour_next};
    assign out_valid_next = tick_en ? 1'b1 : (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg       <= calclk_pkg::SEC_RST;
            min_reg       <= calclk_pkg::MIN_RST;
            hour_reg      <= calclk_pkg::HOUR_RST;
            day_reg       <= calclk_pkg::DAY_RST;
            month_reg     <= calclk_pkg::MONTH_RST;
            year_reg      <= calclk_pkg::YEAR_RST;
            year_hi_reg   <= calclk_pkg::YEAR_HI_RST;
            year_lo_reg   <= calclk_pkg::YEAR_LO_RST;
            view_date_reg <= 1'b0;
            dwell_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            year_hi_reg   <= year_hi_next;
            year_lo_reg   <= year_lo_next;
            view_date_reg <= view_date_next;
            dwell_reg     <= dwell_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_en)
        begin
            out_data_reg <= out_data_next;
            out_date_reg <= view_date_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_date_reg;

endmodule

@@ hw/rtl/calclk_checker.sv @@
// ----------------------------------------------------------------------------
// Calendar clock port checker
// Watches the stream ports of the calendar clock over time.
// ----------------------------------------------------------------------------
module calclk_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [calclk_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                         m_axis_tuser
);

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // With the output register empty, the input side is never held off.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // The time view leaves its two rightmost digits blank.
    a_time_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[55:40] == 16'hFFFF)
        else $error("time view without blank digits");

    // Clock fields stay in range.
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[4:0] < 5'd24 && m_axis_tdata[10:5] < 6'd60 &&
            m_axis_tdata[16:11] < 6'd60)
        else $error("time field out of range");

endmodule

bind calendar_clock_with_segment_display_unit calclk_checker u_calclk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
